// ===== design/combo_random_generator_core_assert.svh =====
// Assertion macros for the combination random generator checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef COMBO_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define COMBO_RANDOM_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crg assertion failed");

`endif

// ===== design/crg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the combination random generator.
// No dependencies; the state, divider, core and checker files refer to this package.
package crg_pkg;

  // Request modes.
  typedef enum logic [1:0] {
    ModeReseed = 2'd0,
    ModeRaw    = 2'd1,
    ModeAbs    = 2'd2,
    ModeMod    = 2'd3
  } mode_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LimitW = 31;
  localparam int unsigned DivSteps = LimitW;
  localparam int unsigned CntW   = $clog2(DivSteps);

  // Multiply-with-carry constants.
  localparam logic [14:0] MwcMult = 15'd30903;
  localparam int unsigned MwcShift = 16;

  // State after reset: the reseed with a zero seed.
  localparam logic [WordW-1:0] LagReset     = 32'd3;
  localparam logic [WordW-1:0] ProductReset = 32'd1;
  localparam logic [WordW-1:0] CarryReset   = 32'd1;

  localparam logic [WordW-1:0] NegMin = 32'h8000_0000;
  localparam logic [LimitW-1:0] PosMax = 31'h7FFF_FFFF;

  typedef logic signed [WordW-1:0] seed_t;

  typedef struct packed {
    mode_e              mode;
    logic [LimitW-1:0]  limit;
  } req_t;

  typedef struct packed {
    logic signed [WordW-1:0] value;
    logic                    divide_error;
  } res_t;

  // Control from the sequencer to the state words.
  typedef struct packed {
    logic load;
    logic step;
  } state_ctrl_t;

  // Control to and status from the remainder unit.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Magnitude of a two's complement word; the most negative value saturates.
  function automatic logic [LimitW-1:0] magnitude(input logic [WordW-1:0] sum);
    logic [WordW-1:0] neg;
    neg = ~sum + 32'd1;
    if (sum == NegMin) begin
      return PosMax;
    end else if (sum[WordW-1]) begin
      return neg[LimitW-1:0];
    end else begin
      return sum[LimitW-1:0];
    end
  endfunction

endpackage

// ===== design/crg_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per handshake.
// The payload type is a parameter; types come from crg_pkg.
interface crg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/crg_state.sv =====
`timescale 1ns / 1ps
// Generator state words: product pair and multiply-with-carry word.
// Uses crg_pkg for widths, constants and the control struct.
module crg_state (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  crg_pkg::state_ctrl_t        ctrl_i,
  input  crg_pkg::seed_t              seed_i,
  output logic [crg_pkg::WordW-1:0]   product_o,
  output logic [crg_pkg::WordW-1:0]   carry_o
);

  logic [crg_pkg::WordW-1:0] lag_q, lag_d;
  logic [crg_pkg::WordW-1:0] product_q, product_d;
  logic [crg_pkg::WordW-1:0] carry_q, carry_d;
  logic [crg_pkg::WordW-1:0] seed_bits;
  logic [crg_pkg::WordW-1:0] prod_full;
  logic [30:0]               mwc_prod;

  assign seed_bits = crg_pkg::WordW'(seed_i);

  // One step: product pair multiply and multiply-with-carry update.
  // The low half times the multiplier is below 2^31, so 31 bits hold it.
  assign prod_full = lag_q * product_q;
  assign mwc_prod  = {15'd0, carry_q[15:0]} * {16'd0, crg_pkg::MwcMult};

  always_comb begin
    lag_d     = lag_q;
    product_d = product_q;
    carry_d   = carry_q;
    if (ctrl_i.load) begin
      lag_d     = {seed_bits[crg_pkg::WordW-4:0], 3'b011};
      product_d = {seed_bits[crg_pkg::WordW-2:0], 1'b1};
      carry_d   = seed_bits | 32'd1;
    end else if (ctrl_i.step) begin
      lag_d     = product_q;
      product_d = prod_full;
      carry_d   = {1'b0, mwc_prod} + {16'd0, carry_q[crg_pkg::WordW-1:crg_pkg::MwcShift]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q     <= crg_pkg::LagReset;
      product_q <= crg_pkg::ProductReset;
      carry_q   <= crg_pkg::CarryReset;
    end else begin
      lag_q     <= lag_d;
      product_q <= product_d;
      carry_q   <= carry_d;
    end
  end

  assign product_o = product_q;
  assign carry_o   = carry_q;

endmodule

// ===== design/crg_divider.sv =====
`timescale 1ns / 1ps
// Restoring remainder unit: one shift and conditional subtract per cycle.
// Uses crg_pkg for widths, step count and the control/status structs.
module crg_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  crg_pkg::div_ctrl_t           ctrl_i,
  input  logic [crg_pkg::LimitW-1:0]   dividend_i,
  input  logic [crg_pkg::LimitW-1:0]   divisor_i,
  output crg_pkg::div_status_t         status_o,
  output logic [crg_pkg::LimitW-1:0]   remainder_o
);

  logic [crg_pkg::LimitW-1:0] rem_q, rem_d;
  logic [crg_pkg::LimitW-1:0] num_q, num_d;
  logic [crg_pkg::LimitW-1:0] div_q, div_d;
  logic [crg_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [crg_pkg::LimitW:0]   trial;
  logic [crg_pkg::LimitW:0]   diff;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, num_q[crg_pkg::LimitW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d  = '0;
      num_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, div_q}) ? diff[crg_pkg::LimitW-1:0]
                                       : trial[crg_pkg::LimitW-1:0];
      num_d = {num_q[crg_pkg::LimitW-2:0], 1'b0};
      cnt_d = cnt_q + crg_pkg::CntW'(1);
      if (cnt_q == crg_pkg::CntW'(crg_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; operands are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign remainder_o   = rem_q;

endmodule

// ===== design/combo_random_generator_core.sv =====
`timescale 1ns / 1ps
// Combination random generator: one request item in, one result item out.
// A reseed loads the state and goes straight to the result; raw, absolute and zero-limit
// modulo step the state, then form the sum; modulo also runs the 31-step remainder loop.
// One request at a time: the next item is taken the cycle after the result is registered,
// and a finished result waits while the previous one is still unaccepted.
// Reset (rst_ni low, asynchronous) loads the zero-seed state, clears the seed and any result.
module combo_random_generator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  crg_stream_if.sink   req_i,
  crg_stream_if.source res_o,
  crg_stream_if.sink   cfg_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StStep = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]                   state_q, state_d;
  crg_pkg::mode_e               mode_q, mode_d;
  logic [crg_pkg::LimitW-1:0]   limit_q, limit_d;
  logic [crg_pkg::WordW-1:0]    result_q, result_d;
  logic                         err_q, err_d;
  crg_pkg::seed_t               seed_q;
  logic                         res_valid_q, res_valid_d;
  crg_pkg::res_t                res_q, res_d;

  crg_pkg::state_ctrl_t         sctrl;
  crg_pkg::div_ctrl_t           dctrl;
  crg_pkg::div_status_t         dstat;
  logic [crg_pkg::WordW-1:0]    product;
  logic [crg_pkg::WordW-1:0]    carry;
  logic [crg_pkg::WordW-1:0]    sum;
  logic [crg_pkg::LimitW-1:0]   mag;
  logic [crg_pkg::LimitW-1:0]   remainder;
  logic                         req_fire;
  logic                         res_free;

  // Seed register; the write channel never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_i.valid) begin
      seed_q <= cfg_i.payload;
    end
  end

  crg_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (sctrl),
    .seed_i    (seed_q),
    .product_o (product),
    .carry_o   (carry)
  );

  crg_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (dctrl),
    .dividend_i  (mag),
    .divisor_i   (limit_q),
    .status_o    (dstat),
    .remainder_o (remainder)
  );

  assign sum      = product + carry;
  assign mag      = crg_pkg::magnitude(sum);
  assign req_fire = req_i.valid && req_i.ready;
  assign res_free = !res_valid_q || res_o.ready;

  assign req_i.ready = (state_q == StIdle);

  // Sequencer over the state words and the remainder unit.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    limit_d     = limit_q;
    result_d    = result_q;
    err_d       = err_q;
    sctrl       = '0;
    dctrl       = '0;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (req_fire) begin
          mode_d   = req_i.payload.mode;
          limit_d  = req_i.payload.limit;
          result_d = '0;
          err_d    = 1'b0;
          if (req_i.payload.mode == crg_pkg::ModeReseed) begin
            sctrl.load = 1'b1;
            state_d    = StFin;
          end else begin
            state_d = StStep;
          end
        end
      end
      StStep: begin
        sctrl.step = 1'b1;
        state_d    = StSum;
      end
      StSum: begin
        state_d = StFin;
        case (mode_q)
          crg_pkg::ModeRaw: result_d = sum;
          crg_pkg::ModeAbs: result_d = {1'b0, mag};
          crg_pkg::ModeMod: begin
            if (limit_q == '0) begin
              err_d = 1'b1;
            end else begin
              dctrl.start = 1'b1;
              state_d     = StDiv;
            end
          end
          default: result_d = '0;
        endcase
      end
      StDiv: begin
        if (dstat.done && !dstat.busy) begin
          result_d = {1'b0, remainder};
          state_d  = StFin;
        end
      end
      StFin: begin
        if (res_free) begin
          res_valid_d        = 1'b1;
          res_d.value        = result_q;
          res_d.divide_error = err_q;
          state_d            = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    limit_q  <= limit_d;
    result_q <= result_d;
    err_q    <= err_d;
    res_q    <= res_d;
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

endmodule

// ===== design/crg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the combination random generator, bound to the top.
// Uses the macros of combo_random_generator_core_assert.svh.
`include "combo_random_generator_core_assert.svh"

module crg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [crg_pkg::WordW-1:0]   res_value_i,
  input logic                        res_err_i
);

  // A stalled result stays offered and unchanged.
  `CRG_ASSERT_NEXT(res_hold_a, res_valid_i && !res_ready_i, res_valid_i)
  `CRG_ASSERT_NEXT(res_stable_a, res_valid_i && !res_ready_i,
                   $stable(res_value_i) && $stable(res_err_i))

  // A divide error always carries a zero value.
  `CRG_ASSERT_SAME(err_zero_a, res_valid_i && res_err_i, res_value_i == '0)

  // Each accepted request keeps the block busy for at least the next cycle.
  `CRG_ASSERT_NEXT(busy_after_accept_a, req_valid_i && req_ready_i, !req_ready_i)

endmodule

bind combo_random_generator_core crg_checker u_crg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_value_i (res_o.payload.value),
  .res_err_i   (res_o.payload.divide_error)
);

// ===== tb/tb_combo_random_generator_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of combo_random_generator_core: a directed table, then random
// requests under three idling patterns, each result checked against an in-bench predictor.
// Depends on crg_pkg, crg_stream_if and the core itself.
module tb_combo_random_generator_core;

  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned TailCycles   = 40;
  localparam int unsigned PhaseItems   = 300;
  localparam int unsigned ItemsPerSeed = 100;
  localparam int unsigned HoldMarkA    = 150;
  localparam int unsigned HoldMarkB    = 450;

  localparam logic [31:0] MostNeg   = 32'h8000_0000;
  localparam logic [31:0] MostPos   = 32'h7FFF_FFFF;
  localparam logic [31:0] AllOnes   = 32'hFFFF_FFFF;
  localparam logic [30:0] LimitMax  = 31'h7FFF_FFFF;
  localparam logic [31:0] MwcFactor = 32'd30903;
  // First raw draw after reset: product 3*1 plus carry 1*30903.
  localparam logic [31:0] FirstDraw = 32'd30906;

  typedef struct packed {
    logic [31:0] lag;
    logic [31:0] prod;
    logic [31:0] carry;
  } gen_state_t;

  typedef struct {
    bit             wr_seed;
    logic [31:0]    seed;
    crg_pkg::mode_e mode;
    logic [30:0]    limit;
    bit             typed;
    crg_pkg::res_t  want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  crg_stream_if #(.payload_t(crg_pkg::req_t))  req_if ();
  crg_stream_if #(.payload_t(crg_pkg::res_t))  res_if ();
  crg_stream_if #(.payload_t(crg_pkg::seed_t)) cfg_if ();

  combo_random_generator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state and the draws still owed by the core.
  gen_state_t    gen;
  logic [31:0]   seed_reg;
  crg_pkg::res_t awaited_draws[$];
  stim_row_t     directed_rows[$];

  int send_idle;
  int recv_idle;
  int fail_count;
  int results_seen;
  int items_sent;
  int mod_items;
  int zero_limit_items;
  int seed_writes;
  int hold_left;
  int holds_taken;
  int quiet;

  // State loaded by a reseed.
  function automatic gen_state_t seeded_state(input logic [31:0] s);
    gen_state_t g;
    g.lag   = {s[28:0], 3'b000} + 32'd3;
    g.prod  = {s[30:0], 1'b0} + 32'd1;
    g.carry = s | 32'd1;
    return g;
  endfunction

  // One step of the product pair and the multiply-with-carry word.
  function automatic gen_state_t stepped_state(input gen_state_t g);
    gen_state_t n;
    n.prod  = g.lag * g.prod;
    n.lag   = g.prod;
    n.carry = {16'd0, g.carry[15:0]} * MwcFactor + {16'd0, g.carry[31:16]};
    return n;
  endfunction

  // Absolute value; the most negative sum saturates.
  function automatic logic [31:0] sat_magnitude(input logic [31:0] sum);
    if (sum == MostNeg) begin
      return MostPos;
    end else if (sum[31]) begin
      return ~sum + 32'd1;
    end
    return sum;
  endfunction

  function automatic logic [31:0] sum_after(input logic [31:0] s, input int k);
    gen_state_t g;
    g = seeded_state(s);
    repeat (k) g = stepped_state(g);
    return g.prod + g.carry;
  endfunction

  // Expected draw for one request; advances the predictor state.
  function automatic crg_pkg::res_t predict_draw(input crg_pkg::req_t r);
    crg_pkg::res_t o;
    logic [31:0] sum;
    o.value = '0;
    o.divide_error = 1'b0;
    if (r.mode == crg_pkg::ModeReseed) begin
      gen = seeded_state(seed_reg);
    end else begin
      gen = stepped_state(gen);
      sum = gen.prod + gen.carry;
      case (r.mode)
        crg_pkg::ModeRaw: begin
          o.value = sum;
        end
        crg_pkg::ModeAbs: begin
          o.value = sat_magnitude(sum);
        end
        default: begin
          if (r.limit == '0) begin
            o.divide_error = 1'b1;
          end else begin
            o.value = sat_magnitude(sum) % {1'b0, r.limit};
          end
        end
      endcase
    end
    return o;
  endfunction

  // Looks for a seed whose first or second draw sums to the most negative word.
  // With s = H*2^16 + L the product word is linear in H, and over each of two
  // ranges of H the carry word is too, so H is solved with an odd inverse.
  function automatic bit find_saturating_seed(output logic [31:0] seed_out,
                                              output int steps_out);
    logic [31:0] c_mul;
    logic [31:0] base_sum;
    logic [31:0] slope;
    logic [31:0] slope_inv;
    logic [31:0] offset;
    logic [31:0] cand;
    int lo;
    int hi;
    seed_out = '0;
    steps_out = 0;
    for (int k = 1; k <= 2; k++) begin
      for (int low = 0; low < 65536; low++) begin
        c_mul = 32'((low | 1) * 30903);
        for (int piece = 0; piece < 2; piece++) begin
          lo = (piece == 0) ? 0 : 65536 - int'(c_mul[15:0]);
          hi = (piece == 0) ? 65535 - int'(c_mul[15:0]) : 65535;
          if (lo <= hi) begin
            base_sum = sum_after({lo[15:0], low[15:0]}, k);
            offset = '0;
            if (lo < hi) begin
              slope = sum_after({16'(lo + 1), low[15:0]}, k) - base_sum;
              slope_inv = slope;
              repeat (5) slope_inv = slope_inv * (32'd2 - slope * slope_inv);
              offset = (MostNeg - base_sum) * slope_inv;
            end
            cand = 32'(lo) + offset;
            if (offset <= 32'(hi - lo) &&
                sum_after({cand[15:0], low[15:0]}, k) == MostNeg) begin
              seed_out = {cand[15:0], low[15:0]};
              steps_out = k;
              return 1'b1;
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic crg_pkg::req_t random_request();
    crg_pkg::req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.mode = crg_pkg::ModeReseed;
    end else if (pick < 35) begin
      r.mode = crg_pkg::ModeRaw;
    end else if (pick < 60) begin
      r.mode = crg_pkg::ModeAbs;
    end else begin
      r.mode = crg_pkg::ModeMod;
    end
    case ($urandom_range(9))
      0: begin
        r.limit = '0;
      end
      1: begin
        r.limit = LimitMax;
      end
      2: begin
        r.limit = 31'(1) << $urandom_range(30);
      end
      3, 4, 5: begin
        r.limit = 31'($urandom_range(300, 1));
      end
      default: begin
        r.limit = 31'($urandom);
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(input bit wr, input logic [31:0] s,
                                  input crg_pkg::mode_e m,
                                  input logic [30:0] lim, input bit typed,
                                  input logic [31:0] v, input bit e);
    stim_row_t row;
    row.wr_seed = wr;
    row.seed = s;
    row.mode = m;
    row.limit = lim;
    row.typed = typed;
    row.want.value = v;
    row.want.divide_error = e;
    directed_rows.push_back(row);
  endfunction

  // Stops offering and waits for every owed draw.
  task automatic drain_draws();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (awaited_draws.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Seed register write, done only with the core idle.
  task automatic write_seed(input logic [31:0] s);
    drain_draws();
    @(negedge clk_i);
    cfg_if.payload = s;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) begin
      @(posedge clk_i);
    end
    seed_reg = s;
    seed_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Offers one request item after a random gap and records its expected draw.
  task automatic offer(input crg_pkg::req_t r, input bit typed, input crg_pkg::res_t want);
    crg_pkg::res_t draw;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.payload = r;
    req_if.valid = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    draw = predict_draw(r);
    awaited_draws.push_back(typed ? want : draw);
    items_sent++;
    if (r.mode == crg_pkg::ModeMod) begin
      mod_items++;
      if (r.limit == '0) begin
        zero_limit_items++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random ready, with long hold-offs once enough draws have come.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else if ((holds_taken == 0 && results_seen >= HoldMarkA) ||
                 (holds_taken == 1 && results_seen >= HoldMarkB)) begin
      res_if.ready = 1'b0;
      hold_left = HoldCycles - 1;
      holds_taken++;
    end else begin
      res_if.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin
    crg_pkg::res_t want;
    crg_pkg::res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      results_seen++;
      if (awaited_draws.size() == 0) begin
        $error("result item with no request outstanding: value %h", got.value);
        fail_count++;
      end else begin
        want = awaited_draws.pop_front();
        if (got.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, got.value);
          fail_count++;
        end
        if (got.divide_error !== want.divide_error) begin
          $error("divide_error: expected %b, got %b", want.divide_error,
                 got.divide_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("Watchdog: %0d cycles without any item moving.", quiet);
        $display("tb_combo_random_generator_core NOT OK");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t     row;
    crg_pkg::req_t r;
    crg_pkg::res_t none;
    logic [31:0]   sat_seed;
    logic [31:0]   pick_seed;
    int            sat_steps;
    bit            sat_found;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    send_idle = 23;
    recv_idle = 72;
    fail_count = 0;
    results_seen = 0;
    items_sent = 0;
    mod_items = 0;
    zero_limit_items = 0;
    seed_writes = 0;
    hold_left = 0;
    holds_taken = 0;
    quiet = 0;
    none = '0;
    seed_reg = '0;
    gen = seeded_state('0);

    sat_found = find_saturating_seed(sat_seed, sat_steps);

    // Directed table: reset state, limit extremes, seed extremes, saturation.
    add_row(0, '0, crg_pkg::ModeRaw, '0, 1, FirstDraw, 0);
    add_row(0, '0, crg_pkg::ModeAbs, 31'h1234_5678, 0, '0, 0);
    add_row(0, '0, crg_pkg::ModeMod, '0, 1, '0, 1);
    add_row(0, '0, crg_pkg::ModeMod, 31'd1, 1, '0, 0);
    add_row(0, '0, crg_pkg::ModeMod, LimitMax, 0, '0, 0);
    add_row(0, '0, crg_pkg::ModeReseed, LimitMax, 1, '0, 0);
    add_row(0, '0, crg_pkg::ModeRaw, LimitMax, 1, FirstDraw, 0);
    add_row(1, MostPos, crg_pkg::ModeReseed, '0, 1, '0, 0);
    add_row(0, '0, crg_pkg::ModeMod, 31'h5555_5555, 0, '0, 0);
    add_row(0, '0, crg_pkg::ModeRaw, '0, 0, '0, 0);
    add_row(1, MostNeg, crg_pkg::ModeReseed, 31'h2AAA_AAAA, 1, '0, 0);
    add_row(0, '0, crg_pkg::ModeAbs, '0, 0, '0, 0);
    add_row(0, '0, crg_pkg::ModeMod, 31'h2AAA_AAAA, 0, '0, 0);
    add_row(1, AllOnes, crg_pkg::ModeReseed, '0, 1, '0, 0);
    add_row(0, '0, crg_pkg::ModeRaw, LimitMax, 0, '0, 0);
    if (sat_found) begin
      // Raw shows the most negative sum; absolute and modulo saturate it.
      add_row(1, sat_seed, crg_pkg::ModeReseed, '0, 1, '0, 0);
      repeat (sat_steps - 1) add_row(0, '0, crg_pkg::ModeRaw, '0, 0, '0, 0);
      add_row(0, '0, crg_pkg::ModeRaw, '0, 1, MostNeg, 0);
      add_row(0, '0, crg_pkg::ModeReseed, '0, 1, '0, 0);
      repeat (sat_steps - 1) add_row(0, '0, crg_pkg::ModeRaw, '0, 0, '0, 0);
      add_row(0, '0, crg_pkg::ModeAbs, '0, 1, MostPos, 0);
      add_row(0, '0, crg_pkg::ModeReseed, '0, 1, '0, 0);
      repeat (sat_steps - 1) add_row(0, '0, crg_pkg::ModeRaw, '0, 0, '0, 0);
      add_row(0, '0, crg_pkg::ModeMod, LimitMax, 1, '0, 0);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.wr_seed) begin
        write_seed(row.seed);
      end
      r.mode = row.mode;
      r.limit = row.limit;
      offer(r, row.typed, row.want);
    end

    // Random part in three idling patterns, reseeding the register now and then.
    for (int p = 0; p < 3; p++) begin
      drain_draws();
      send_idle = (p == 0) ? 23 : ((p == 1) ? 72 : 0);
      recv_idle = (p == 0) ? 72 : ((p == 1) ? 23 : 0);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % ItemsPerSeed == 0) begin
          case ($urandom_range(3))
            0: begin
              pick_seed = '0;
            end
            1: begin
              pick_seed = MostPos;
            end
            2: begin
              pick_seed = MostNeg;
            end
            default: begin
              pick_seed = $urandom;
            end
          endcase
          write_seed(pick_seed);
        end
        offer(random_request(), 0, none);
      end
    end

    drain_draws();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d requests (%0d directed), %0d modulo of which %0d with zero limit,",
             items_sent, directed_rows.size(), mod_items, zero_limit_items);
    $display("%0d seed writes, %0d long receiver holds, saturating seed %s.",
             seed_writes, holds_taken, sat_found ? "exercised" : "not available");
    if (fail_count == 0) begin
      $display("tb_combo_random_generator_core OK");
    end else begin
      $display("tb_combo_random_generator_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/crg_pkg.sv
design/crg_stream_if.sv
design/crg_state.sv
design/crg_divider.sv
design/combo_random_generator_core.sv
design/crg_checker.sv
tb/tb_combo_random_generator_core.sv
